// File: rtl/pts_pkg.sv
// shared types and constants of the process table scheduler
`default_nettype none
package pts_pkg;

  // slot state codes
  localparam logic [1:0] ST_INVALID = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_STOPPED = 2'd3;

  // scheduling policies, the unused code runs as lottery
  localparam logic [1:0] MODE_FIFO    = 2'd0;
  localparam logic [1:0] MODE_PRIO    = 2'd1;
  localparam logic [1:0] MODE_LOTTERY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_UPRIO   = 2'd1;
  localparam logic [1:0] REG_QUANTUM = 2'd2;

  // item actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_YIELD = 1'b1;

  // lottery scan passes
  localparam logic [1:0] PASS_MAXN  = 2'd0;
  localparam logic [1:0] PASS_TOTAL = 2'd1;
  localparam logic [1:0] PASS_DRAW  = 2'd2;

  localparam int RND_W = 32;

  // one slot table entry
  typedef struct packed {
    logic [1:0]        state;
    logic signed [7:0] prio;
    logic [5:0]        nice;
    logic [31:0]       cpu;
    logic [15:0]       wait_cnt;
  } entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CUR_RD,
    S_CUR_WR,
    S_SCAN,
    S_DIV,
    S_FIN_RD,
    S_FIN_WR
  } seq_state_t;

endpackage
`default_nettype wire

// File: rtl/process_table_scheduler_core.sv
// top level: slot table scheduler with scan sequencer
//
//  channel  | signals                                   | transfer
//  ---------+-------------------------------------------+--------------------------
//  item in  | start, busy, action, slot .. random_value | start && !busy
//  result   | result_valid, chosen_slot, switched       | result_valid, one cycle
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
//  a write item is stored from idle without leaving it; a yield runs the scan
//  sequencer, in lottery mode with extra scans and a draw: each table
//  scan reads one slot a cycle through the single memory read port, and the
//  draw runs a 32-step remainder unit
//  after reset a clearing pass zeroes the table, busy is high
//  the result strobe lasts one cycle and cannot be stalled
`default_nettype none
module process_table_scheduler_core #(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action,
  input  wire logic [5:0]  slot,
  input  wire logic [1:0]  state_code,
  input  wire logic signed [7:0] prio_value,
  input  wire logic [5:0]  nice_value,
  input  wire logic [31:0] cpu_time,
  input  wire logic [15:0] wait_value,
  input  wire logic [31:0] random_value,
  output logic             result_valid,
  output logic [5:0]       chosen_slot,
  output logic             switched,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import pts_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int TW = $clog2(NUM_SLOTS * 64);

  seq_state_t state, state_next;

  // configuration
  logic [1:0]        sched_mode;
  logic signed [7:0] user_priority;
  logic [15:0]       quantum;

  // scheduler registers
  logic [SW-1:0]   current_slot;
  logic [SW-1:0]   chosen;
  logic [CW-1:0]   clr_idx;
  logic [CW-1:0]   iss;
  logic            rd_vld;
  logic [SW-1:0]   rd_idx;
  logic [1:0]      pass;
  logic [31:0]     rnd;
  entry_t          cand_entry;
  logic            have;
  logic [5:0]      maxn;
  logic [TW-1:0]   total;
  logic [TW-1:0]   sum;
  logic [TW-1:0]   ticket;
  logic            found;

  // memory ports
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [SW-1:0] mem_raddr;
  entry_t        rdata;

  // remainder unit
  logic          div_start;
  logic          div_done;
  logic [TW-1:0] div_rem;

  // decoded conditions
  logic          slot_ok;
  logic          is_fifo;
  logic          is_prio;
  logic          is_lot;
  logic          scan_end;
  logic          eval_ready;
  logic [6:0]    tk;
  logic [TW-1:0] sum_next;
  logic          better;
  logic [15:0]   aged_cand;
  logic [15:0]   aged_slot;

  assign cfg_ready  = 1'b1;
  assign busy       = (state != S_IDLE);
  assign slot_ok    = (32'(slot) < NUM_SLOTS);
  assign is_fifo    = (sched_mode == MODE_FIFO);
  assign is_prio    = (sched_mode == MODE_PRIO);
  assign is_lot     = !is_fifo && !is_prio;
  assign scan_end   = (iss == CW'(NUM_SLOTS)) && !rd_vld;
  assign eval_ready = rd_vld && (rd_idx != '0) && (rdata.state == ST_READY);
  assign tk         = 7'(maxn) + 7'd1 - 7'(rdata.nice);
  assign sum_next   = sum + TW'(tk);
  assign aged_cand  = (cand_entry.wait_cnt == 16'hFFFF) ? cand_entry.wait_cnt
                                                        : cand_entry.wait_cnt + 16'd1;
  assign aged_slot  = (rdata.wait_cnt == 16'hFFFF) ? rdata.wait_cnt
                                                   : rdata.wait_cnt + 16'd1;

  // priority order: priority, then nice, then cpu time, later slot on ties
  always_comb begin
    better = 1'b0;
    if (rdata.prio < cand_entry.prio) begin
      better = 1'b1;
    end else if (rdata.prio == cand_entry.prio) begin
      if (rdata.nice < cand_entry.nice) begin
        better = 1'b1;
      end else if (rdata.nice == cand_entry.nice && rdata.cpu <= cand_entry.cpu) begin
        better = 1'b1;
      end
    end
  end

  pts_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .AW    (SW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  pts_mod_unit #(
    .DW (TW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rnd),
    .divisor   (total),
    .done      (div_done),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == CW'(NUM_SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start && action == ACT_YIELD) state_next = S_CUR_RD;
      end
      S_CUR_RD: state_next = S_CUR_WR;
      S_CUR_WR: state_next = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          if (!is_lot || pass == PASS_DRAW) begin
            state_next = S_FIN_RD;
          end else if (pass == PASS_TOTAL) begin
            state_next = (total == '0) ? S_FIN_RD : S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) state_next = S_SCAN;
      end
      S_FIN_RD: state_next = S_FIN_WR;
      S_FIN_WR: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory ports and unit control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    div_start = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx[SW-1:0];
      end
      S_IDLE: begin
        if (start && action == ACT_WRITE && slot_ok) begin
          mem_we    = 1'b1;
          mem_waddr = SW'(slot);
          mem_wdata = '{state: state_code, prio: prio_value, nice: nice_value,
                        cpu: cpu_time, wait_cnt: wait_value};
        end
      end
      S_CUR_RD: mem_raddr = current_slot;
      S_CUR_WR: begin
        if (rdata.state == ST_RUNNING) begin
          mem_we             = 1'b1;
          mem_waddr          = current_slot;
          mem_wdata          = rdata;
          mem_wdata.state    = ST_READY;
          mem_wdata.wait_cnt = '0;
        end
      end
      S_SCAN: begin
        if (iss < CW'(NUM_SLOTS)) mem_raddr = iss[SW-1:0];
        // fifo aging writes back the slot passed over
        if (is_fifo && eval_ready) begin
          mem_we = 1'b1;
          if (rdata.wait_cnt > cand_entry.wait_cnt) begin
            mem_waddr          = chosen;
            mem_wdata          = cand_entry;
            mem_wdata.wait_cnt = aged_cand;
          end else begin
            mem_waddr          = rd_idx;
            mem_wdata          = rdata;
            mem_wdata.wait_cnt = aged_slot;
          end
        end
        div_start = scan_end && is_lot && pass == PASS_TOTAL && total != '0;
      end
      S_DIV:    mem_raddr = chosen;
      S_FIN_RD: mem_raddr = chosen;
      S_FIN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = chosen;
        mem_wdata = '{state: ST_RUNNING, prio: user_priority, nice: rdata.nice,
                      cpu: rdata.cpu, wait_cnt: quantum};
      end
      default: mem_we = 1'b0;
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      current_slot  <= '0;
      result_valid  <= 1'b0;
      rd_vld        <= 1'b0;
      sched_mode    <= MODE_LOTTERY;
      user_priority <= 8'sd40;
      quantum       <= 16'd50;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;

      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:    sched_mode    <= cfg_data[1:0];
          REG_UPRIO:   user_priority <= signed'(cfg_data[7:0]);
          REG_QUANTUM: quantum       <= cfg_data;
          default:     sched_mode    <= sched_mode;
        endcase
      end

      case (state)
        S_CLEAR: clr_idx <= clr_idx + 1'b1;
        S_IDLE: begin
          if (start && action == ACT_YIELD) begin
            rnd    <= random_value;
            chosen <= '0;
            have   <= 1'b0;
            maxn   <= '0;
            total  <= '0;
            sum    <= '0;
            found  <= 1'b0;
            pass   <= PASS_MAXN;
          end
        end
        S_CUR_WR: begin
          iss    <= '0;
          rd_vld <= 1'b0;
        end
        S_SCAN: begin
          // issue one read a cycle
          rd_idx <= iss[SW-1:0];
          if (iss < CW'(NUM_SLOTS)) begin
            iss    <= iss + 1'b1;
            rd_vld <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
          // evaluate the slot read last cycle
          if (rd_vld && is_fifo && rd_idx == '0) begin
            cand_entry <= rdata;
          end
          if (eval_ready) begin
            if (is_fifo) begin
              if (rdata.wait_cnt > cand_entry.wait_cnt) begin
                chosen     <= rd_idx;
                cand_entry <= rdata;
              end
            end else if (is_prio) begin
              if (!have || better) begin
                have       <= 1'b1;
                chosen     <= rd_idx;
                cand_entry <= rdata;
              end
            end else begin
              case (pass)
                PASS_MAXN: begin
                  if (rdata.nice > maxn) maxn <= rdata.nice;
                end
                PASS_TOTAL: total <= total + TW'(tk);
                default: begin
                  if (!found) begin
                    sum <= sum_next;
                    if (sum_next > ticket) begin
                      found  <= 1'b1;
                      chosen <= rd_idx;
                    end
                  end
                end
              endcase
            end
          end
          if (scan_end) begin
            pass <= pass + 1'b1;
            iss  <= '0;
          end
        end
        S_DIV: begin
          if (div_done) ticket <= div_rem;
        end
        S_FIN_WR: begin
          result_valid <= 1'b1;
          chosen_slot  <= 6'(chosen);
          switched     <= (chosen != current_slot);
          current_slot <= chosen;
        end
        default: rd_vld <= rd_vld;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/pts_slot_mem.sv
// slot table memory, one write port and one registered read port
`default_nettype none
module pts_slot_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  pts_pkg::entry_t      wdata,
  input  wire logic [AW-1:0]   raddr,
  output pts_pkg::entry_t      rdata
);
  import pts_pkg::*;

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/pts_mod_unit.sv
// restoring remainder unit, one dividend bit per cycle
`default_nettype none
module pts_mod_unit #(
  parameter int DW = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [pts_pkg::RND_W-1:0] dividend,
  input  wire logic [DW-1:0]             divisor,
  output logic                           done,
  output logic [DW-1:0]                  remainder
);
  import pts_pkg::*;

  localparam int CNT_W = $clog2(RND_W);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [RND_W-1:0] dq;
  logic [DW-1:0]    dv;
  logic [DW:0]      trial;
  logic [DW:0]      rem_next;

  // one shift and subtract step
  always_comb begin
    trial = {remainder, dq[RND_W-1]};
    if (trial >= {1'b0, dv}) begin
      rem_next = trial - {1'b0, dv};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run       <= 1'b1;
        cnt       <= '0;
        dq        <= dividend;
        dv        <= divisor;
        remainder <= '0;
      end else if (run) begin
        remainder <= rem_next[DW-1:0];
        dq        <= {dq[RND_W-2:0], 1'b0};
        cnt       <= cnt + 1'b1;
        if (cnt == CNT_W'(RND_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/pts_checker.sv
// port checker for the process table scheduler, bound to the top level
`default_nettype none
module pts_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic action,
  input wire logic result_valid,
  input wire logic cfg_ready
);
  import pts_pkg::*;

  // the clearing pass keeps items out after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // a yield transfer starts a multi-cycle scan
  a_yield_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_YIELD) |=> busy)
    else $error("yield did not start a scan");

  // a write transfer never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_WRITE) |=> !result_valid)
    else $error("result after a slot write");

  // a result only follows a busy scan
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(busy) && !busy))
    else $error("result without a preceding scan");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind process_table_scheduler_core pts_checker u_pts_checker (.*);
`default_nettype wire

// File: tb/process_table_scheduler_core_tb.sv
// testbench of the process table scheduler core: random slot writes and yields against a predictor
`timescale 1ns / 1ps
module process_table_scheduler_core_tb;
  import pts_pkg::*;

  localparam int NSLOT = 64;

  // one pending item
  typedef struct {
    logic        act;
    logic [5:0]  idx;
    logic [1:0]  st;
    logic signed [7:0] pr;
    logic [5:0]  nc;
    logic [31:0] cpu;
    logic [15:0] wt;
    logic [31:0] rnd;
  } job_t;

  typedef struct {
    logic [5:0] pick;
    logic       sw;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic action = 1'b0;
  logic [5:0] slot = '0;
  logic [1:0] state_code = '0;
  logic signed [7:0] prio_value = '0;
  logic [5:0] nice_value = '0;
  logic [31:0] cpu_time = '0;
  logic [15:0] wait_value = '0;
  logic [31:0] random_value = '0;
  logic result_valid;
  logic [5:0] chosen_slot;
  logic switched;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  process_table_scheduler_core #(.NUM_SLOTS(NSLOT)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .slot(slot),
    .state_code(state_code), .prio_value(prio_value), .nice_value(nice_value),
    .cpu_time(cpu_time), .wait_value(wait_value), .random_value(random_value),
    .result_valid(result_valid), .chosen_slot(chosen_slot), .switched(switched),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor copy of the table and registers
  logic [1:0]        tbl_st [NSLOT];
  logic signed [7:0] tbl_pr [NSLOT];
  logic [5:0]        tbl_nc [NSLOT];
  logic [31:0]       tbl_cpu [NSLOT];
  logic [15:0]       tbl_wt [NSLOT];
  logic [5:0]        cur_slot;
  logic [1:0]        mode_reg;
  logic signed [7:0] uprio_reg;
  logic [15:0]       quantum_reg;

  job_t  pending_jobs[$];
  pick_t expected_picks[$];
  int    fail_count = 0;
  int    sent_count = 0;
  int    gap_left = 0;
  bit    allow_gaps = 1'b1;

  function automatic void bump_wait(int i);
    if (tbl_wt[i] != 16'hFFFF) tbl_wt[i] = tbl_wt[i] + 16'd1;
  endfunction

  // apply one accepted item to the predictor, queue the pick of a yield
  function automatic void schedule_step(job_t j);
    int chosen;
    int prev;
    bit have;
    logic [31:0] maxn, total, sum, ticket;
    pick_t p;
    if (j.act == ACT_WRITE) begin
      tbl_st[j.idx] = j.st;
      tbl_pr[j.idx] = j.pr;
      tbl_nc[j.idx] = j.nc;
      tbl_cpu[j.idx] = j.cpu;
      tbl_wt[j.idx] = j.wt;
      return;
    end
    prev = cur_slot;
    if (tbl_st[prev] == ST_RUNNING) begin
      tbl_st[prev] = ST_READY;
      tbl_wt[prev] = '0;
    end
    chosen = 0;
    if (mode_reg == MODE_FIFO) begin
      for (int i = 1; i < NSLOT; i++) begin
        if (tbl_st[i] != ST_READY) continue;
        if (tbl_wt[i] > tbl_wt[chosen]) begin
          bump_wait(chosen);
          chosen = i;
        end else bump_wait(i);
      end
    end else if (mode_reg == MODE_PRIO) begin
      have = 1'b0;
      for (int i = 1; i < NSLOT; i++) begin
        if (tbl_st[i] != ST_READY) continue;
        if (!have) begin
          chosen = i;
          have = 1'b1;
        end else if (tbl_pr[i] < tbl_pr[chosen]) chosen = i;
        else if (tbl_pr[i] == tbl_pr[chosen]) begin
          if (tbl_nc[i] < tbl_nc[chosen]) chosen = i;
          else if (tbl_nc[i] == tbl_nc[chosen] && tbl_cpu[i] <= tbl_cpu[chosen]) chosen = i;
        end
      end
    end else begin
      maxn = 0;
      total = 0;
      sum = 0;
      for (int i = 1; i < NSLOT; i++)
        if (tbl_st[i] == ST_READY && tbl_nc[i] > maxn) maxn = 32'(tbl_nc[i]);
      for (int i = 1; i < NSLOT; i++)
        if (tbl_st[i] == ST_READY) total += maxn + 1 - 32'(tbl_nc[i]);
      if (total != 0) begin
        ticket = j.rnd % total;
        for (int i = 1; i < NSLOT; i++) begin
          if (tbl_st[i] != ST_READY) continue;
          sum += maxn + 1 - 32'(tbl_nc[i]);
          if (sum > ticket) begin
            chosen = i;
            break;
          end
        end
      end
    end
    tbl_pr[chosen] = uprio_reg;
    tbl_st[chosen] = ST_RUNNING;
    tbl_wt[chosen] = quantum_reg;
    cur_slot = 6'(chosen);
    p.pick = 6'(chosen);
    p.sw = (chosen != prev);
    expected_picks.push_back(p);
  endfunction

  // driver: present queued items, with random gaps
  always @(negedge clk) begin
    if (!rst) begin
      if (start) begin
        // start was raised while not busy, so the transfer happened at the rising edge
        start <= 1'b0;
        if (allow_gaps && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 17);
      end else if (!busy && pending_jobs.size() > 0) begin
        if (gap_left > 0) gap_left--;
        else begin
          job_t j;
          j = pending_jobs.pop_front();
          action <= j.act;
          slot <= j.idx;
          state_code <= j.st;
          prio_value <= j.pr;
          nice_value <= j.nc;
          cpu_time <= j.cpu;
          wait_value <= j.wt;
          random_value <= j.rnd;
          start <= 1'b1;
        end
      end
    end
  end

  // monitor: predict on input transfer, check each result strobe
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        job_t j;
        j.act = action; j.idx = slot; j.st = state_code; j.pr = prio_value;
        j.nc = nice_value; j.cpu = cpu_time; j.wt = wait_value; j.rnd = random_value;
        schedule_step(j);
        sent_count++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODE) mode_reg = cfg_data[1:0];
        else if (cfg_index == REG_UPRIO) uprio_reg = cfg_data[7:0];
        else if (cfg_index == REG_QUANTUM) quantum_reg = cfg_data;
      end
      if (result_valid) begin
        if (expected_picks.size() == 0) begin
          $display("%0t: result with none expected: slot %0d switched %0b",
                   $time, chosen_slot, switched);
          fail_count++;
        end else begin
          pick_t p;
          p = expected_picks.pop_front();
          if (chosen_slot !== p.pick) begin
            $display("%0t: chosen_slot expected %0d actual %0d", $time, p.pick, chosen_slot);
            fail_count++;
          end
          if (switched !== p.sw) begin
            $display("%0t: switched expected %0b actual %0b", $time, p.sw, switched);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for all items and results, then let a lottery yield finish
  task automatic drain_all();
    while (pending_jobs.size() > 0 || start || busy || expected_picks.size() > 0)
      @(posedge clk);
    repeat (3 * NSLOT + 60) @(posedge clk);
  endtask

  function automatic job_t write_job(int idx, logic [1:0] st, logic signed [7:0] pr,
                                     logic [5:0] nc, logic [31:0] cpu, logic [15:0] wt);
    job_t j;
    j.act = ACT_WRITE; j.idx = 6'(idx); j.st = st; j.pr = pr; j.nc = nc;
    j.cpu = cpu; j.wt = wt; j.rnd = $urandom;
    return j;
  endfunction

  function automatic job_t yield_job(logic [31:0] rnd);
    job_t j;
    j = write_job($urandom_range(0, 63), 2'($urandom), 8'($urandom), 6'($urandom), $urandom,
                  16'($urandom));
    j.act = ACT_YIELD;
    j.rnd = rnd;
    return j;
  endfunction

  // random item: mostly ready slots in a narrow index range so picks compete
  function automatic job_t rand_job(int span);
    logic [1:0] st;
    if ($urandom_range(0, 2) == 0) return yield_job($urandom);
    st = ($urandom_range(0, 3) != 0) ? ST_READY : 2'($urandom);
    return write_job(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, span),
                     st, 8'($urandom), $urandom_range(0, 7) == 0 ? 6'($urandom) :
                     6'($urandom_range(0, 39)), ($urandom_range(0, 3) == 0) ?
                     $urandom_range(0, 3) : $urandom,
                     ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 20)));
  endfunction

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl_st[i] = '0; tbl_pr[i] = '0; tbl_nc[i] = '0; tbl_cpu[i] = '0; tbl_wt[i] = '0;
    end
    cur_slot = '0;
    mode_reg = MODE_LOTTERY;
    uprio_reg = 8'sd40;
    quantum_reg = 16'd50;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, ties, saturation, every policy
    pending_jobs.push_back(yield_job(32'hFFFFFFFF));
    pending_jobs.push_back(write_job(63, ST_READY, -8'sd128, 6'd63, 32'hFFFFFFFF, 16'hFFFF));
    pending_jobs.push_back(write_job(1, ST_READY, 8'sd127, 6'd0, 32'd0, 16'hFFFF));
    pending_jobs.push_back(write_job(2, ST_STOPPED, -8'sd128, 6'd39, 32'd0, 16'd0));
    pending_jobs.push_back(write_job(3, ST_RUNNING, 8'sd0, 6'd1, 32'd7, 16'd3));
    pending_jobs.push_back(yield_job(32'd0));
    pending_jobs.push_back(yield_job(32'hFFFFFFFF));
    drain_all();
    reg_write(REG_MODE, 16'(MODE_FIFO));
    reg_write(REG_QUANTUM, 16'hFFFF);
    reg_write(REG_UPRIO, 16'h0080);
    pending_jobs.push_back(yield_job(32'd5));
    pending_jobs.push_back(yield_job(32'd5));
    pending_jobs.push_back(write_job(0, ST_READY, 8'sd0, 6'd0, 32'd0, 16'd0));
    pending_jobs.push_back(yield_job(32'd5));
    drain_all();
    reg_write(REG_MODE, 16'(MODE_PRIO));
    reg_write(REG_UPRIO, 16'h007F);
    reg_write(REG_QUANTUM, 16'd0);
    pending_jobs.push_back(write_job(4, ST_READY, 8'sd5, 6'd2, 32'd9, 16'd0));
    pending_jobs.push_back(write_job(5, ST_READY, 8'sd5, 6'd2, 32'd9, 16'd0));
    pending_jobs.push_back(yield_job(32'd1));
    pending_jobs.push_back(yield_job(32'd1));
    drain_all();
    reg_write(REG_MODE, 16'd3);
    reg_write(2'd3, 16'hFFFF);
    pending_jobs.push_back(yield_job(32'd12345));
    pending_jobs.push_back(write_job(0, ST_INVALID, 8'sd0, 6'd0, 32'd0, 16'd0));
    pending_jobs.push_back(yield_job(32'd2));
    drain_all();

    // random phases across policies and register settings
    for (int ph = 0; ph < 14; ph++) begin
      int span;
      span = (ph % 3 == 0) ? 63 : $urandom_range(2, 12);
      reg_write(REG_MODE, 16'($urandom_range(0, 3)));
      reg_write(REG_UPRIO, (ph == 1) ? 16'h0080 : (ph == 2) ? 16'h007F : 16'($urandom));
      reg_write(REG_QUANTUM, (ph == 3) ? 16'hFFFF : (ph == 4) ? 16'd0 :
                16'($urandom_range(0, 40)));
      allow_gaps = (ph < 12);
      for (int k = 0; k < 125; k++) pending_jobs.push_back(rand_job(span));
      drain_all();
    end

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
